// ===== hdl/mlfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds request codes, sizes, the sequencer state type and reset constants. No dependencies.
`default_nettype none
package mlfq_pkg;

   localparam int MAX_THREADS = 128;
   localparam int NUM_LEVELS  = 7;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_EVENT  = 3'd1;
   localparam logic [2:0] REQ_WAKE   = 3'd2;
   localparam logic [2:0] REQ_SET_TL = 3'd3;
   localparam logic [2:0] REQ_CLR_TL = 3'd4;

   localparam logic [1:0] DISP_READY = 2'd0;

   localparam logic CSR_BOOST_PERIOD = 1'b0;
   localparam logic CSR_TIME_UNIT    = 1'b1;

   localparam logic [15:0] BOOST_PERIOD_RESET = 16'd100;
   localparam logic [9:0]  TIME_UNIT_RESET    = 10'd25;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_REQUEUE,
      ST_BOOST_CHK,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_BOOST_MOVE,
      ST_PICK,
      ST_POP_RD,
      ST_POP_WR,
      ST_MULT,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/multilevel_feedback_queue_scheduler_unit.sv =====
// Top level of the multilevel feedback queue scheduler.
// Uses mlfq_pkg. Per-thread levels and list links live in two synchronous memories inside this module.
//
// A request is taken when start is high and busy is low; each request gives exactly
// one response, strobed on rsp_valid for one cycle, which the receiver cannot hold off.
// A create, wake or temporary-level request passes lookup and requeue before the
// response; a refused create or wake or an unknown type goes from lookup straight to
// the response. An event passes requeue, the promotion check and the pick, then pops
// the queue head and works out the quantum if it dispatches a thread; with every queue
// empty it goes from the pick to the response. A due promotion first walks each list
// below level 0 through the link memory one entry at a time. Busy stays high from the
// cycle after acceptance through the response cycle, so the next request can be taken
// in the cycle after the response. The level and link memories need no clearing pass;
// one flag stands in for the main thread's level until its entry is first written.
`default_nettype none
module multilevel_feedback_queue_scheduler_unit
   import mlfq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [6:0]  req_thread_id,
   input  wire logic [1:0]  req_disposition,
   input  wire logic [2:0]  req_temp_level,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output logic             rsp_valid,
   output logic [6:0]       rsp_run_thread,
   output logic             rsp_run_valid,
   output logic [2:0]       rsp_run_level,
   output logic [12:0]      rsp_quantum,
   output logic             rsp_switched,
   output logic             rsp_error
);

   localparam int TW = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
   localparam int LW = $clog2(NUM_LEVELS);
   localparam int CW = TW + 1;
   localparam logic [LW-1:0] LAST = LW'(NUM_LEVELS - 1);

   typedef struct packed {
      logic [LW-1:0] lvl;
      logic [LW-1:0] blvl;
   } ent_type;

   // Per-thread memories: level info and list links.
   ent_type         ent_mem [MAX_THREADS];
   logic [TW-1:0]   link_mem[MAX_THREADS];
   ent_type         ent_rd_ff;
   logic [TW-1:0]   ent_ra_ff;
   ent_type         ent_q;
   logic [TW-1:0]   link_rd_ff;
   logic [TW-1:0]   ent_addr, link_addr, ent_waddr, link_waddr;
   ent_type         ent_wdata;
   logic [TW-1:0]   link_wdata;
   logic            ent_we, link_we;
   logic            main_new_ff, main_new_in;

   logic [MAX_THREADS-1:0] inq_ff, inq_in;
   logic [MAX_THREADS-1:0] bact_ff, bact_in;

   logic [TW-1:0] qh_ff[NUM_LEVELS], qh_in[NUM_LEVELS];
   logic [TW-1:0] qt_ff[NUM_LEVELS], qt_in[NUM_LEVELS];
   logic [CW-1:0] qc_ff[NUM_LEVELS], qc_in[NUM_LEVELS];

   state_type     st_ff, st_in;
   logic [2:0]    req_ff, req_in;
   logic [6:0]    id_ff, id_in;
   logic [1:0]    disp_ff, disp_in;
   logic [2:0]    tl_ff, tl_in;
   logic [TW-1:0] rt_ff, rt_in;
   logic          rv_ff, rv_in;
   logic [LW-1:0] rl_ff, rl_in;
   logic [15:0]   ec_ff, ec_in;
   logic [15:0]   bp_ff;
   logic [9:0]    tu_ff;
   logic [LW-1:0] k_ff, k_in;
   logic [CW-1:0] n_ff, n_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic          sw_ff, sw_in, err_ff, err_in;
   logic [12:0]   qn_ff, qn_in;

   logic          id_ok;
   logic [TW-1:0] idt;
   logic [LW-1:0] push_lvl;
   logic [TW-1:0] push_id;
   logic          push_en;

   assign id_ok = ({25'd0, id_ff} < 32'(MAX_THREADS));
   assign idt   = TW'(id_ff);
   assign busy      = (st_ff != ST_IDLE);
   assign csr_ready = (st_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      if (link_we) link_mem[link_waddr] <= link_wdata;
      ent_rd_ff  <= ent_mem[ent_addr];
      ent_ra_ff  <= ent_addr;
      link_rd_ff <= link_mem[link_addr];
   end

   // The main thread runs at level 0 from reset before its entry is ever written.
   always_comb begin
      ent_q = ent_rd_ff;
      if (main_new_ff && ent_ra_ff == '0) ent_q.lvl = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         inq_ff <= '0;
         bact_ff <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            qh_ff[i] <= '0;
            qt_ff[i] <= '0;
            qc_ff[i] <= '0;
         end
         rt_ff <= '0;
         rv_ff <= 1'b1;
         rl_ff <= '0;
         ec_ff <= '0;
         bp_ff <= BOOST_PERIOD_RESET;
         tu_ff <= TIME_UNIT_RESET;
         main_new_ff <= 1'b1;
      end else begin
         st_ff <= st_in;
         inq_ff <= inq_in;
         bact_ff <= bact_in;
         qh_ff <= qh_in;
         qt_ff <= qt_in;
         qc_ff <= qc_in;
         rt_ff <= rt_in;
         rv_ff <= rv_in;
         rl_ff <= rl_in;
         ec_ff <= ec_in;
         main_new_ff <= main_new_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BOOST_PERIOD) bp_ff <= csr_wdata;
            else tu_ff <= csr_wdata[9:0];
         end
      end
      req_ff <= req_in;
      id_ff <= id_in;
      disp_ff <= disp_in;
      tl_ff <= tl_in;
      k_ff <= k_in;
      n_ff <= n_in;
      cur_ff <= cur_in;
      sw_ff <= sw_in;
      err_ff <= err_in;
      qn_ff <= qn_in;
   end

   always_comb begin
      st_in = st_ff;
      inq_in = inq_ff;
      bact_in = bact_ff;
      qh_in = qh_ff;
      qt_in = qt_ff;
      qc_in = qc_ff;
      rt_in = rt_ff;
      rv_in = rv_ff;
      rl_in = rl_ff;
      ec_in = ec_ff;
      req_in = req_ff;
      id_in = id_ff;
      disp_in = disp_ff;
      tl_in = tl_ff;
      k_in = k_ff;
      n_in = n_ff;
      cur_in = cur_ff;
      sw_in = sw_ff;
      err_in = err_ff;
      qn_in = qn_ff;
      main_new_in = main_new_ff;
      ent_addr = idt;
      link_addr = cur_ff;
      ent_we = 1'b0;
      ent_waddr = idt;
      ent_wdata = ent_q;
      link_we = 1'b0;
      link_waddr = '0;
      link_wdata = '0;
      push_en = 1'b0;
      push_lvl = '0;
      push_id = idt;
      rsp_valid = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_type;
               id_in = req_thread_id;
               disp_in = req_disposition;
               tl_in = req_temp_level;
               sw_in = 1'b0;
               err_in = 1'b0;
               qn_in = '0;
               st_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Address the running thread on events, the request's thread otherwise.
            ent_addr = (req_ff == REQ_EVENT) ? rt_ff : idt;
            st_in = ST_REQUEUE;
            if (req_ff == REQ_EVENT) begin
               ec_in = ec_ff + 16'd1;
            end else if (!id_ok || req_ff > REQ_CLR_TL) begin
               st_in = ST_RESP;
            end else if ((req_ff == REQ_CREATE || req_ff == REQ_WAKE) &&
                         (inq_ff[idt] || (rv_ff && rt_ff == idt))) begin
               err_in = 1'b1;
               st_in = ST_RESP;
            end
         end
         ST_REQUEUE: begin
            st_in = ST_RESP;
            case (req_ff)
               REQ_CREATE: begin
                  ent_we = 1'b1;
                  ent_wdata = ent_q;
                  ent_wdata.lvl = '0;
                  bact_in[idt] = 1'b0;
                  push_en = 1'b1;
                  push_lvl = '0;
               end
               REQ_WAKE: begin
                  push_en = 1'b1;
                  push_lvl = (ent_q.lvl > LAST) ? LAST : ent_q.lvl;
               end
               REQ_SET_TL: begin
                  ent_we = 1'b1;
                  ent_wdata = ent_q;
                  ent_wdata.blvl = ({1'b0, tl_ff} > 4'(NUM_LEVELS - 1)) ? LAST
                                                                           : LW'(tl_ff);
                  bact_in[idt] = 1'b1;
               end
               REQ_CLR_TL: bact_in[idt] = 1'b0;
               default: begin
                  st_in = ST_BOOST_CHK;
                  if (rv_ff && disp_ff == DISP_READY && !inq_ff[rt_ff]) begin
                     push_en = 1'b1;
                     push_id = rt_ff;
                     if (bact_ff[rt_ff]) begin
                        push_lvl = ent_q.blvl;
                     end else begin
                        push_lvl = (ent_q.lvl >= LAST) ? LAST : ent_q.lvl + 1'b1;
                        ent_we = 1'b1;
                        ent_waddr = rt_ff;
                        ent_wdata = ent_q;
                        ent_wdata.lvl = push_lvl;
                     end
                  end
               end
            endcase
         end
         ST_BOOST_CHK: begin
            st_in = ST_PICK;
            if (ec_ff >= bp_ff) begin
               ec_in = '0;
               k_in = LW'(1);
               n_in = '0;
               cur_in = qh_ff[1];
               st_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            // Read level and link of the current list entry, or move on once the list is done.
            if (n_ff >= qc_ff[k_ff]) begin
               if (k_ff == LAST) begin
                  st_in = ST_BOOST_MOVE;
               end else begin
                  k_in = k_ff + 1'b1;
                  n_in = '0;
                  cur_in = qh_ff[k_ff + 1'b1];
               end
            end else begin
               ent_addr = cur_ff;
               link_addr = cur_ff;
               st_in = ST_WALK_WR;
            end
         end
         ST_WALK_WR: begin
            ent_we = 1'b1;
            ent_waddr = cur_ff;
            ent_wdata = ent_q;
            if (ent_q.lvl != '0) ent_wdata.lvl = ent_q.lvl - 1'b1;
            cur_in = link_rd_ff;
            n_in = n_ff + 1'b1;
            st_in = ST_WALK_RD;
         end
         ST_BOOST_MOVE: begin
            if (qc_ff[1] != '0) begin
               if (qc_ff[0] == '0) begin
                  qh_in[0] = qh_ff[1];
               end else begin
                  link_we = 1'b1;
                  link_waddr = qt_ff[0];
                  link_wdata = qh_ff[1];
               end
               qt_in[0] = qt_ff[1];
               qc_in[0] = qc_ff[0] + qc_ff[1];
            end
            for (int i = 1; i < NUM_LEVELS - 1; i++) begin
               qh_in[i] = qh_ff[i + 1];
               qt_in[i] = qt_ff[i + 1];
               qc_in[i] = qc_ff[i + 1];
            end
            qc_in[NUM_LEVELS - 1] = '0;
            st_in = ST_PICK;
         end
         ST_PICK: begin
            rv_in = 1'b0;
            rt_in = '0;
            rl_in = '0;
            st_in = ST_RESP;
            for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
               if (qc_ff[i] != '0) begin
                  k_in = LW'(i);
                  st_in = ST_POP_RD;
               end
            end
         end
         ST_POP_RD: begin
            link_addr = qh_ff[k_ff];
            st_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            rt_in = qh_ff[k_ff];
            rv_in = 1'b1;
            rl_in = k_ff;
            sw_in = 1'b1;
            inq_in[qh_ff[k_ff]] = 1'b0;
            qc_in[k_ff] = qc_ff[k_ff] - 1'b1;
            if (qc_ff[k_ff] != CW'(1)) qh_in[k_ff] = link_rd_ff;
            st_in = ST_MULT;
         end
         ST_MULT: begin
            qn_in = (k_ff == LAST) ? '0 : (13'(tu_ff) * (13'(k_ff) + 13'd1));
            st_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase

      if (push_en) begin
         if (qc_ff[push_lvl] == '0) begin
            qh_in[push_lvl] = push_id;
         end else begin
            link_we = 1'b1;
            link_waddr = qt_ff[push_lvl];
            link_wdata = push_id;
         end
         qt_in[push_lvl] = push_id;
         qc_in[push_lvl] = qc_ff[push_lvl] + 1'b1;
         inq_in[push_id] = 1'b1;
      end

      if (ent_we && ent_waddr == '0) main_new_in = 1'b0;
   end

   assign rsp_run_thread = rv_ff ? 7'(rt_ff) : 7'd0;
   assign rsp_run_valid  = rv_ff;
   assign rsp_run_level  = rv_ff ? 3'(rl_ff) : 3'd0;
   assign rsp_quantum    = qn_ff;
   assign rsp_switched   = sw_ff;
   assign rsp_error      = err_ff;

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("response not followed by idle");
   a_err_noswitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_switched) else $error("refused request switched");
   a_quantum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_switched |-> rsp_quantum == 13'd0) else $error("stray quantum");
   a_run_notq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> !inq_ff[rt_ff]) else $error("running thread queued");

endmodule
`default_nettype wire

// ===== dv/multilevel_feedback_queue_scheduler_unit_test.sv =====
// Self-checking testbench for the multilevel feedback queue scheduler unit.
// Depends on mlfq_pkg and the scheduler top level; a scoreboard class predicts each response.
`default_nettype none

class sched_scoreboard;
   logic [15:0] boost_period;
   logic [9:0]  time_unit;
   logic [6:0]  q_head [7];
   logic [6:0]  q_tail [7];
   int unsigned q_count [7];
   logic [6:0]  link [128];
   logic [2:0]  level [128];
   bit          tl_on [128];
   logic [2:0]  tl_lvl [128];
   bit          queued [128];
   bit          created [128];
   logic [6:0]  run_id;
   bit          run_ok;
   logic [2:0]  run_lvl;
   logic [15:0] events;
   logic [25:0] pending [$];
   int          mismatches;
   int          switches;
   int          boosts;

   function new();
      boost_period = mlfq_pkg::BOOST_PERIOD_RESET;
      time_unit = mlfq_pkg::TIME_UNIT_RESET;
      for (int k = 0; k < 7; k++) begin
         q_head[k] = 0; q_tail[k] = 0; q_count[k] = 0;
      end
      for (int i = 0; i < 128; i++) begin
         link[i] = 0; level[i] = 0; tl_on[i] = 0; tl_lvl[i] = 0;
         queued[i] = 0; created[i] = 0;
      end
      created[0] = 1;
      run_id = 0; run_ok = 1; run_lvl = 0; events = 0;
      mismatches = 0; switches = 0; boosts = 0;
   endfunction

   function void write_csr(bit idx, logic [15:0] v);
      if (idx == mlfq_pkg::CSR_BOOST_PERIOD) boost_period = v;
      else time_unit = v[9:0];
   endfunction

   function void enqueue(int lv, logic [6:0] id);
      if (q_count[lv] == 0) q_head[lv] = id;
      else link[q_tail[lv]] = id;
      q_tail[lv] = id;
      q_count[lv]++;
      queued[id] = 1;
   endfunction

   function void promote();
      logic [6:0] id;
      for (int k = 1; k < 7; k++) begin
         id = q_head[k];
         for (int n = 0; n < q_count[k]; n++) begin
            if (level[id] > 0) level[id]--;
            id = link[id];
         end
      end
      if (q_count[1] != 0) begin
         if (q_count[0] == 0) q_head[0] = q_head[1];
         else link[q_tail[0]] = q_head[1];
         q_tail[0] = q_tail[1];
         q_count[0] += q_count[1];
      end
      for (int k = 1; k < 6; k++) begin
         q_head[k] = q_head[k+1]; q_tail[k] = q_tail[k+1]; q_count[k] = q_count[k+1];
      end
      q_count[6] = 0;
      boosts++;
   endfunction

   // Notes an accepted request and queues the response it must produce.
   function void note_request(logic [2:0] rt, logic [6:0] id, logic [1:0] disp,
                              logic [2:0] tl);
      logic [12:0] quantum;
      bit sw, err, busy_id;
      int lv;
      quantum = 0; sw = 0; err = 0;
      busy_id = queued[id] || (run_ok && run_id == id);
      case (rt)
         mlfq_pkg::REQ_CREATE: begin
            if (busy_id) err = 1;
            else begin
               level[id] = 0; tl_on[id] = 0; created[id] = 1; enqueue(0, id);
            end
         end
         mlfq_pkg::REQ_WAKE: begin
            if (busy_id) err = 1;
            else enqueue(level[id], id);
         end
         mlfq_pkg::REQ_SET_TL: begin
            tl_on[id] = 1; tl_lvl[id] = (tl > 6) ? 3'd6 : tl;
         end
         mlfq_pkg::REQ_CLR_TL: tl_on[id] = 0;
         mlfq_pkg::REQ_EVENT: begin
            events = 16'(events + 1);
            if (run_ok && disp == mlfq_pkg::DISP_READY && !queued[run_id]) begin
               if (tl_on[run_id]) lv = tl_lvl[run_id];
               else begin
                  lv = (level[run_id] >= 6) ? 6 : level[run_id] + 1;
                  level[run_id] = 3'(lv);
               end
               enqueue(lv, run_id);
            end
            if (events >= boost_period) begin
               events = 0;
               promote();
            end
            run_ok = 0; run_id = 0; run_lvl = 0;
            for (int k = 0; k < 7; k++) begin
               if (q_count[k] != 0) begin
                  run_id = q_head[k];
                  q_count[k]--;
                  if (q_count[k] != 0) q_head[k] = link[run_id];
                  queued[run_id] = 0;
                  run_ok = 1; run_lvl = 3'(k); sw = 1; switches++;
                  quantum = (k == 6) ? 13'd0 : 13'(time_unit * (k + 1));
                  break;
               end
            end
         end
         default: ;
      endcase
      pending.push_back({run_ok ? run_id : 7'd0, run_ok, run_ok ? run_lvl : 3'd0,
                         quantum, sw, err});
   endfunction

   function void check_response(logic [25:0] got);
      logic [25:0] exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", got);
         return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch (exp/act): thread %0d/%0d valid %0d/%0d level %0d/%0d",
                     exp[25:19], got[25:19], exp[18], got[18], exp[17:15], got[17:15]);
            $display("   quantum %0d/%0d sw %0d/%0d err %0d/%0d",
                     exp[14:2], got[14:2], exp[1], got[1], exp[0], got[0]);
         end
      end
   endfunction
endclass

module multilevel_feedback_queue_scheduler_unit_test;
   import mlfq_pkg::*;

   logic clock, reset, start, busy;
   logic [2:0] req_type;
   logic [6:0] req_thread_id;
   logic [1:0] req_disposition;
   logic [2:0] req_temp_level;
   logic csr_valid, csr_ready, csr_index;
   logic [15:0] csr_wdata;
   logic rsp_valid, rsp_run_valid, rsp_switched, rsp_error;
   logic [6:0] rsp_run_thread;
   logic [2:0] rsp_run_level;
   logic [12:0] rsp_quantum;

   sched_scoreboard sb;
   int requests;

   multilevel_feedback_queue_scheduler_unit dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response({rsp_run_thread, rsp_run_valid, rsp_run_level, rsp_quantum,
                            rsp_switched, rsp_error});
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send(logic [2:0] rt, logic [6:0] id, logic [1:0] disp, logic [2:0] tl);
      start <= 1; req_type <= rt; req_thread_id <= id;
      req_disposition <= disp; req_temp_level <= tl;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(rt, id, disp, tl);
      requests++;
      start <= 0;
      req_type <= 3'($urandom); req_thread_id <= 7'($urandom);
      req_disposition <= 2'($urandom); req_temp_level <= 3'($urandom);
      @(posedge clock);
      idle_gap();
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(bit idx, logic [15:0] v);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_csr(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Picks an id that has been created, so a wake never reads an unwritten level.
   function automatic logic [6:0] known_id();
      logic [6:0] id;
      id = 7'($urandom);
      while (!sb.created[id]) id = 7'($urandom);
      return id;
   endfunction

   task automatic random_phase(int count, int max_id);
      int pick;
      logic [6:0] id;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         id = 7'($urandom_range(0, max_id));
         if (pick < 25) send(REQ_CREATE, id, 2'($urandom), 3'($urandom));
         else if (pick < 60) send(REQ_EVENT, 7'($urandom), ($urandom_range(0, 2) == 0) ?
                                  2'($urandom) : DISP_READY, 3'($urandom));
         else if (pick < 78) send(REQ_WAKE, known_id(), 2'($urandom), 3'($urandom));
         else if (pick < 88) send(REQ_SET_TL, id, 2'($urandom), 3'($urandom));
         else if (pick < 96) send(REQ_CLR_TL, id, 2'($urandom), 3'($urandom));
         else send(3'($urandom_range(5, 7)), 7'($urandom), 2'($urandom), 3'($urandom));
      end
   endtask

   initial begin
      sb = new();
      requests = 0;
      reset = 1; start = 0; req_type = 0; req_thread_id = 0;
      req_disposition = 0; req_temp_level = 0;
      csr_valid = 0; csr_index = 0; csr_wdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: busy ids, idle events, temporary levels, unknown types, extreme ids.
      send(REQ_CREATE, 7'd0, 0, 0);
      send(REQ_WAKE, 7'd0, 0, 0);
      send(REQ_CREATE, 7'd127, 0, 0);
      send(REQ_CREATE, 7'd127, 0, 0);
      send(REQ_CREATE, 7'd1, 0, 0);
      send(REQ_SET_TL, 7'd127, 0, 3'd7);
      send(REQ_SET_TL, 7'd1, 0, 3'd2);
      send(REQ_EVENT, 0, DISP_READY, 0);
      send(REQ_EVENT, 0, DISP_READY, 0);
      send(REQ_EVENT, 0, 2'd1, 0);
      send(REQ_EVENT, 0, 2'd3, 0);
      send(REQ_EVENT, 0, 2'd2, 0);
      send(REQ_EVENT, 0, 2'd3, 0);
      send(REQ_EVENT, 0, DISP_READY, 0);
      send(REQ_WAKE, 7'd1, 0, 0);
      send(REQ_CLR_TL, 7'd127, 0, 0);
      send(REQ_WAKE, 7'd127, 0, 0);
      send(3'd5, 7'd5, 0, 0);
      send(3'd7, 7'd127, 3, 7);
      send(REQ_EVENT, 0, DISP_READY, 0);
      send(REQ_EVENT, 0, DISP_READY, 0);
      drain();

      write_reg(CSR_BOOST_PERIOD, 16'd1);
      write_reg(CSR_TIME_UNIT, 16'd1023);
      random_phase(300, 15);
      drain();
      write_reg(CSR_BOOST_PERIOD, 16'd5);
      write_reg(CSR_TIME_UNIT, 16'd1);
      random_phase(350, 127);
      drain();
      write_reg(CSR_BOOST_PERIOD, 16'd0);
      random_phase(150, 31);
      drain();
      write_reg(CSR_BOOST_PERIOD, 16'd65535);
      write_reg(CSR_TIME_UNIT, 16'd317);
      random_phase(300, 127);
      drain();
      write_reg(CSR_BOOST_PERIOD, 16'd12);
      random_phase(200, 63);
      drain();

      $display("Ran %0d requests with %0d dispatches and %0d promotions over five settings.",
               requests, sb.switches, sb.boosts);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
